// ===== rtl/tekd_pkg.sv =====
`timescale 1ns / 1ps

package tekd_pkg;

    // Parameter characters kept after CSI (2..15, must fit count_reg)
    localparam int PARAM_KEEP = 7;
    localparam int CNT_W      = 4;
    localparam int VAL_W      = 7;

    localparam logic [VAL_W-1:0] PARAM_MAX = 7'd127;

    localparam logic [7:0] BYTE_BS       = 8'd8;
    localparam logic [7:0] BYTE_LF       = 8'd10;
    localparam logic [7:0] BYTE_CR       = 8'd13;
    localparam logic [7:0] BYTE_ESC      = 8'd27;
    localparam logic [7:0] BYTE_DEL      = 8'h7F;
    localparam logic [7:0] BYTE_LBRACKET = 8'h5B;
    localparam logic [7:0] BYTE_TILDE    = 8'h7E;
    localparam logic [7:0] BYTE_KEY_A    = 8'h41;
    localparam logic [7:0] BYTE_KEY_B    = 8'h42;
    localparam logic [7:0] BYTE_KEY_C    = 8'h43;
    localparam logic [7:0] BYTE_KEY_D    = 8'h44;
    localparam logic [7:0] BYTE_DIGIT0   = 8'h30;
    localparam logic [7:0] BYTE_DIGIT9   = 8'h39;
    localparam logic [7:0] BYTE_PAR_END  = 8'h40;
    localparam logic [7:0] BYTE_INTER_LO = 8'h20;

    localparam int NUM_FKEYS = 12;
    localparam logic [VAL_W-1:0] FKEY_CODES [NUM_FKEYS] = '{
        7'd11, 7'd12, 7'd13, 7'd14, 7'd15, 7'd17,
        7'd18, 7'd19, 7'd20, 7'd21, 7'd23, 7'd24
    };

    typedef enum logic [4:0] {
        EV_NONE    = 5'd0,
        EV_CHAR    = 5'd1,
        EV_BKSP    = 5'd2,
        EV_ENTER   = 5'd3,
        EV_ALTCHAR = 5'd4,
        EV_ALTBKSP = 5'd5,
        EV_UP      = 5'd6,
        EV_DN      = 5'd7,
        EV_LEFT    = 5'd8,
        EV_RIGHT   = 5'd9,
        EV_HOME    = 5'd10,
        EV_INS     = 5'd11,
        EV_DELKEY  = 5'd12,
        EV_END     = 5'd13,
        EV_PGUP    = 5'd14,
        EV_PGDN    = 5'd15,
        EV_ALTDEL  = 5'd16,
        EV_FKEY    = 5'd17,
        EV_ALTFKEY = 5'd18
    } event_t;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_PAR   = 3'b010,
        PH_INTER = 3'b100
    } phase_t;

    typedef struct packed {
        event_t     evt;
        logic [7:0] char_code;
        logic [3:0] fkey_number;
    } tekd_result_t;

    // F-key number 1..12 for a parameter value, 0 when it names no F-key
    function automatic logic [3:0] fkey_lookup(input logic [VAL_W-1:0] v);
        logic [3:0] num;
        num = 4'd0;
        for (int i = 0; i < NUM_FKEYS; i++)
        begin
            if (FKEY_CODES[i] == v)
            begin
                num = 4'(i + 1);
            end
        end
        return num;
    endfunction

endpackage

// ===== rtl/tekd_decode.sv =====
`timescale 1ns / 1ps

module tekd_decode
    import tekd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         step,      // consume byte_in this cycle
    input  logic [7:0]   byte_in,
    output tekd_result_t res
);

    logic             escape_seen_reg, escape_seen_next;
    phase_t           phase_reg, phase_next;
    logic             alt_reg, alt_next;
    logic [VAL_W-1:0] value_reg, value_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             stopped_reg, stopped_next;

    logic [10:0]      value_acc;
    logic [3:0]       fk_num;
    logic             in_csi;

    assign value_acc = 11'(value_reg) * 11'd10 + 11'(byte_in - BYTE_DIGIT0);
    assign fk_num    = fkey_lookup(value_reg);
    assign in_csi    = (phase_reg != PH_IDLE);

    always_comb
    begin
        escape_seen_next = escape_seen_reg;
        phase_next       = phase_reg;
        alt_next         = alt_reg;
        value_next       = value_reg;
        count_next       = count_reg;
        stopped_next     = stopped_reg;
        res.evt          = EV_NONE;
        res.char_code    = 8'd0;
        res.fkey_number  = 4'd0;

        if (!escape_seen_reg)
        begin
            if (byte_in == BYTE_ESC)
            begin
                escape_seen_next = 1'b1;
                phase_next       = PH_IDLE;
                alt_next         = 1'b0;
                value_next       = '0;
                count_next       = '0;
                stopped_next     = 1'b0;
            end
            else if (byte_in == BYTE_BS || byte_in == BYTE_DEL)
            begin
                res.evt = EV_BKSP;
            end
            else if (byte_in == BYTE_LF)
            begin
                res.evt = EV_NONE;
            end
            else if (byte_in == BYTE_CR)
            begin
                res.evt = EV_ENTER;
            end
            else
            begin
                res.evt       = EV_CHAR;
                res.char_code = byte_in;
            end
        end
        else if (!in_csi)
        begin
            if (byte_in == BYTE_LBRACKET)
            begin
                phase_next = PH_PAR;
            end
            else if (byte_in == BYTE_ESC)
            begin
                alt_next = 1'b1;
            end
            else if (byte_in == BYTE_BS || byte_in == BYTE_DEL)
            begin
                res.evt          = EV_ALTBKSP;
                escape_seen_next = 1'b0;
            end
            else
            begin
                res.evt          = EV_ALTCHAR;
                res.char_code    = byte_in;
                escape_seen_next = 1'b0;
            end
        end
        else
        begin
            if (byte_in >= BYTE_DIGIT0 && byte_in < BYTE_PAR_END)
            begin
                // parameter chars are dropped once the intermediate phase starts
                if (phase_reg == PH_PAR && count_reg < CNT_W'(PARAM_KEEP))
                begin
                    count_next = count_reg + 1'b1;
                    if (!stopped_reg)
                    begin
                        if (byte_in <= BYTE_DIGIT9)
                        begin
                            value_next = (value_acc > 11'(PARAM_MAX)) ? PARAM_MAX
                                                                      : value_acc[VAL_W-1:0];
                        end
                        else
                        begin
                            stopped_next = 1'b1;
                        end
                    end
                end
            end
            else if (byte_in >= BYTE_INTER_LO && byte_in < BYTE_DIGIT0)
            begin
                phase_next = PH_INTER;
            end
            else if (byte_in >= BYTE_PAR_END && byte_in < BYTE_DEL)
            begin
                // final byte: decode the key, then close the sequence
                case (byte_in)
                    BYTE_KEY_A: res.evt = EV_UP;
                    BYTE_KEY_B: res.evt = EV_DN;
                    BYTE_KEY_C: res.evt = EV_RIGHT;
                    BYTE_KEY_D: res.evt = EV_LEFT;
                    BYTE_TILDE:
                    begin
                        if (value_reg >= 7'd1 && value_reg <= 7'd6)
                        begin
                            res.evt = event_t'(5'(EV_HOME) + 5'(value_reg) - 5'd1);
                            if (res.evt == EV_DELKEY && alt_reg)
                            begin
                                res.evt = EV_ALTDEL;
                            end
                        end
                        else if (fk_num != 4'd0)
                        begin
                            res.evt         = alt_reg ? EV_ALTFKEY : EV_FKEY;
                            res.fkey_number = fk_num;
                        end
                    end
                    default: res.evt = EV_NONE;
                endcase
                escape_seen_next = 1'b0;
                phase_next       = PH_IDLE;
                alt_next         = 1'b0;
                value_next       = '0;
                count_next       = '0;
                stopped_next     = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            escape_seen_reg <= 1'b0;
            phase_reg       <= PH_IDLE;
            alt_reg         <= 1'b0;
            value_reg       <= '0;
            count_reg       <= '0;
            stopped_reg     <= 1'b0;
        end
        else if (step)
        begin
            escape_seen_reg <= escape_seen_next;
            phase_reg       <= phase_next;
            alt_reg         <= alt_next;
            value_reg       <= value_next;
            count_reg       <= count_next;
            stopped_reg     <= stopped_next;
        end
    end

`ifndef SYNTHESIS
    a_csi_needs_esc: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_IDLE) |-> escape_seen_reg)
        else $error("CSI phase active without pending escape");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(PARAM_KEEP))
        else $error("parameter count beyond keep limit");

    a_stopped_in_csi: assert property (@(posedge clk) disable iff (!rst_n)
        stopped_reg |-> (phase_reg != PH_IDLE))
        else $error("parameter stop flag set outside CSI");

    a_fkey_event: assert property (@(posedge clk) disable iff (!rst_n)
        (res.fkey_number != 4'd0) |-> (res.evt == EV_FKEY || res.evt == EV_ALTFKEY))
        else $error("F-key number on a non F-key event");

    a_open_esc: assert property (@(posedge clk) disable iff (!rst_n)
        (step && !escape_seen_reg && byte_in == BYTE_ESC)
        |=> (escape_seen_reg && phase_reg == PH_IDLE && !alt_reg && value_reg == '0))
        else $error("opening ESC did not reset sequence state");
`endif

endmodule

// ===== rtl/tekd_out_reg.sv =====
`timescale 1ns / 1ps

module tekd_out_reg
    import tekd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         load,
    input  tekd_result_t res,
    output logic         can_load,
    output logic         valid,
    input  logic         ready,
    output tekd_result_t data
);

    logic         valid_reg;
    tekd_result_t data_reg;

    // a held beat leaves this cycle if the sink takes it
    assign can_load = !valid_reg || ready;
    assign valid    = valid_reg;
    assign data     = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (can_load)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && can_load)
        begin
            data_reg <= res;
        end
    end

endmodule

// ===== rtl/terminal_escape_key_decoder.sv =====
`timescale 1ns / 1ps
// Path: a byte accepted into the input register is decoded by the decode step into the
// output register, whose key event shows on m_tdata; a stalled sink holds the step.
// Throughput: one byte per cycle; input register, decode step and output register
// all advance together whenever the output register is free or being drained.
// Reset: rst_n is asynchronous, active low; clears the escape/CSI state and both
// valid flags. No state is left in a partial sequence after reset.

module terminal_escape_key_decoder
    import tekd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [4:0] event_res, [12:5] char_code,
                                   // [16:13] fkey_number, [23:17] zero
);

    // Input register: one byte waiting for the decode step
    logic         in_valid_reg;
    logic [7:0]   byte_reg;

    logic         out_can_load;
    logic         step;
    tekd_result_t dec_res;
    tekd_result_t out_res;

    // The decode step fires when a byte is held and the output register can
    // take its event; the key state only moves on that step.
    assign step     = in_valid_reg && out_can_load;
    assign s_tready = !in_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            byte_reg <= s_tdata;
        end
    end

    tekd_decode u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .byte_in (byte_reg),
        .res     (dec_res)
    );

    // Result register decouples the sink from the decoder
    tekd_out_reg u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (step),
        .res      (dec_res),
        .can_load (out_can_load),
        .valid    (m_tvalid),
        .ready    (m_tready),
        .data     (out_res)
    );

    assign m_tdata = {7'd0, out_res.fkey_number, out_res.char_code, 5'(out_res.evt)};

endmodule

// ===== bench/terminal_escape_key_decoder_tb.sv =====
`timescale 1ns / 1ps

module terminal_escape_key_decoder_tb
    import tekd_pkg::*;
();

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 3;
    localparam int RANDOM_BYTES = 1850;
    localparam int HOLD_CYCLES  = 300;     // long m_tready hold-off to back up the pipe
    localparam int DRAIN_CYCLES = 8;       // margin after the last expected event
    localparam int CYCLE_LIMIT  = 400000;

    // One stimulus byte; when known is set the expected key event is typed in,
    // otherwise the predictor supplies it.
    typedef struct packed {
        logic [7:0] b;
        logic       known;
        event_t     evt;
        logic [7:0] cc;
        logic [3:0] fk;
    } key_row_t;

    localparam int N_DIRECTED = 27;

    // Directed walk: plain byte classes, ESC handling, alt prefix, CSI digit
    // saturation, junk inside CSI, a final that names no key, alt F-key and an arrow.
    key_row_t directed_rows [N_DIRECTED] = '{
        '{8'h00,         1'b1, EV_CHAR,    8'h00, 4'd0},  // lowest byte
        '{8'hFF,         1'b1, EV_CHAR,    8'hFF, 4'd0},  // highest byte
        '{BYTE_BS,       1'b1, EV_BKSP,    8'h00, 4'd0},
        '{BYTE_LF,       1'b1, EV_NONE,    8'h00, 4'd0},  // line feed is silent
        '{BYTE_CR,       1'b1, EV_ENTER,   8'h00, 4'd0},
        '{BYTE_ESC,      1'b1, EV_NONE,    8'h00, 4'd0},
        '{BYTE_ESC,      1'b1, EV_NONE,    8'h00, 4'd0},  // second ESC: alt prefix
        '{BYTE_DEL,      1'b1, EV_ALTBKSP, 8'h00, 4'd0},
        '{BYTE_ESC,      1'b1, EV_NONE,    8'h00, 4'd0},
        '{8'h71,         1'b1, EV_ALTCHAR, 8'h71, 4'd0},
        '{BYTE_ESC,      1'b0, EV_NONE,    8'h00, 4'd0},
        '{BYTE_LBRACKET, 1'b0, EV_NONE,    8'h00, 4'd0},
        '{BYTE_DIGIT9,   1'b0, EV_NONE,    8'h00, 4'd0},
        '{BYTE_DIGIT9,   1'b0, EV_NONE,    8'h00, 4'd0},
        '{BYTE_DIGIT9,   1'b0, EV_NONE,    8'h00, 4'd0},  // 999 saturates
        '{8'h80,         1'b0, EV_NONE,    8'h00, 4'd0},  // high byte ignored in CSI
        '{BYTE_ESC,      1'b0, EV_NONE,    8'h00, 4'd0},  // ESC ignored in CSI
        '{BYTE_TILDE,    1'b0, EV_NONE,    8'h00, 4'd0},  // names no key
        '{BYTE_ESC,      1'b0, EV_NONE,    8'h00, 4'd0},
        '{BYTE_ESC,      1'b0, EV_NONE,    8'h00, 4'd0},
        '{BYTE_LBRACKET, 1'b0, EV_NONE,    8'h00, 4'd0},
        '{8'h32,         1'b0, EV_NONE,    8'h00, 4'd0},
        '{8'h34,         1'b0, EV_NONE,    8'h00, 4'd0},
        '{BYTE_TILDE,    1'b0, EV_NONE,    8'h00, 4'd0},  // alt F12
        '{BYTE_ESC,      1'b0, EV_NONE,    8'h00, 4'd0},
        '{BYTE_LBRACKET, 1'b0, EV_NONE,    8'h00, 4'd0},
        '{BYTE_KEY_A,    1'b0, EV_NONE,    8'h00, 4'd0}
    };

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;     // [7:0] byte_in
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;     // [4:0] event_res, [12:5] char_code, [16:13] fkey_number

    terminal_escape_key_decoder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Decoder model state
    logic       esc_open;
    logic       alt_on;
    phase_t     csi_ph;
    logic [6:0] par_val;
    logic [3:0] par_cnt;
    logic       par_stop;

    key_row_t     byte_plan [$];
    tekd_result_t key_expect_q [$];

    int  tx_idle_pct;
    int  rx_stall_pct;
    bit  hold_req;
    int  fail_cnt;
    int  cycle_cnt;

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Key decoder predictor
    // ------------------------------------------------------------------
    function automatic void drop_sequence();
        csi_ph   = PH_IDLE;
        alt_on   = 1'b0;
        par_val  = '0;
        par_cnt  = '0;
        par_stop = 1'b0;
    endfunction

    function automatic tekd_result_t predict_key(input logic [7:0] b);
        tekd_result_t r;
        int           acc;
        r = '{evt: EV_NONE, char_code: 8'd0, fkey_number: 4'd0};
        if (!esc_open)
        begin
            // plain byte classes
            if (b == BYTE_ESC)
            begin
                esc_open = 1'b1;
                drop_sequence();
            end
            else if (b == BYTE_BS || b == BYTE_DEL)
                r.evt = EV_BKSP;
            else if (b == BYTE_LF)
                r.evt = EV_NONE;
            else if (b == BYTE_CR)
                r.evt = EV_ENTER;
            else
            begin
                r.evt       = EV_CHAR;
                r.char_code = b;
            end
        end
        else if (csi_ph == PH_IDLE)
        begin
            // just after ESC
            if (b == BYTE_LBRACKET)
                csi_ph = PH_PAR;
            else if (b == BYTE_ESC)
                alt_on = 1'b1;
            else if (b == BYTE_BS || b == BYTE_DEL)
            begin
                r.evt    = EV_ALTBKSP;
                esc_open = 1'b0;
            end
            else
            begin
                r.evt       = EV_ALTCHAR;
                r.char_code = b;
                esc_open    = 1'b0;
            end
        end
        else if (b >= BYTE_DIGIT0 && b < BYTE_PAR_END)
        begin
            // parameter chars count only in the parameter phase, up to the keep limit
            if (csi_ph == PH_PAR && par_cnt < PARAM_KEEP)
            begin
                par_cnt = par_cnt + 4'd1;
                if (!par_stop)
                begin
                    if (b <= BYTE_DIGIT9)
                    begin
                        acc = int'(par_val) * 10 + int'(b - BYTE_DIGIT0);
                        par_val = (acc > int'(PARAM_MAX)) ? PARAM_MAX : acc[6:0];
                    end
                    else
                        par_stop = 1'b1;
                end
            end
        end
        else if (b >= BYTE_INTER_LO && b < BYTE_DIGIT0)
            csi_ph = PH_INTER;
        else if (b >= BYTE_PAR_END && b < BYTE_DEL)
        begin
            // final byte
            if (b == BYTE_KEY_A)
                r.evt = EV_UP;
            else if (b == BYTE_KEY_B)
                r.evt = EV_DN;
            else if (b == BYTE_KEY_C)
                r.evt = EV_RIGHT;
            else if (b == BYTE_KEY_D)
                r.evt = EV_LEFT;
            else if (b == BYTE_TILDE)
            begin
                if (par_val >= 7'd1 && par_val <= 7'd6)
                begin
                    r.evt = event_t'(EV_HOME + par_val - 7'd1);
                    if (r.evt == EV_DELKEY && alt_on)
                        r.evt = EV_ALTDEL;
                end
                else
                begin
                    for (int i = 0; i < NUM_FKEYS; i++)
                    begin
                        if (FKEY_CODES[i] == par_val)
                            r.fkey_number = 4'(i + 1);
                    end
                    if (r.fkey_number != 4'd0)
                        r.evt = alt_on ? EV_ALTFKEY : EV_FKEY;
                end
            end
            drop_sequence();
            esc_open = 1'b0;
        end
        // anything else inside CSI is dropped silently
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Random traffic: mostly well-formed ESC/CSI sequences with random
    // content, plus raw noise and broken sequences.
    // ------------------------------------------------------------------
    function automatic void push_byte(input logic [7:0] b);
        key_row_t r;
        r = '{b: b, known: 1'b0, evt: EV_NONE, cc: 8'h00, fk: 4'd0};
        byte_plan.push_back(r);
    endfunction

    function automatic logic [7:0] csi_junk();
        case ($urandom_range(2))
            0:       return 8'($urandom_range(31));
            1:       return BYTE_DEL;
            default: return 8'($urandom_range(255, 128));
        endcase
    endfunction

    task automatic build_key_traffic(input int n_bytes);
        int    stop_at;
        int    roll;
        int    v;
        string digits;
        stop_at = byte_plan.size() + n_bytes;
        while (byte_plan.size() < stop_at)
        begin
            roll = $urandom_range(99);
            if (roll < 18)
                push_byte(8'($urandom));
            else if (roll < 28)
            begin
                case ($urandom_range(4))
                    0:       push_byte(BYTE_BS);
                    1:       push_byte(BYTE_DEL);
                    2:       push_byte(BYTE_LF);
                    3:       push_byte(BYTE_CR);
                    default: push_byte(8'($urandom_range(126, 32)));
                endcase
            end
            else
            begin
                push_byte(BYTE_ESC);
                if ($urandom_range(99) < 30)
                    push_byte(BYTE_ESC);
                if ($urandom_range(99) < 15)
                begin
                    // alt char / alt backspace, or a stray byte that may break things
                    case ($urandom_range(2))
                        0:       push_byte(BYTE_BS);
                        1:       push_byte(BYTE_DEL);
                        default: push_byte(8'($urandom));
                    endcase
                end
                else
                begin
                    push_byte(BYTE_LBRACKET);
                    roll = $urandom_range(99);
                    if (roll < 40)
                        v = FKEY_CODES[$urandom_range(NUM_FKEYS - 1)];
                    else if (roll < 70)
                        v = $urandom_range(6, 1);
                    else if (roll < 85)
                        v = $urandom_range(9999);
                    else
                        v = -1;     // no parameter
                    if (v >= 0)
                    begin
                        repeat ($urandom_range(99) < 20 ? $urandom_range(3, 1) : 0)
                            push_byte(BYTE_DIGIT0);
                        digits = $sformatf("%0d", v);
                        for (int k = 0; k < digits.len(); k++)
                            push_byte(digits[k]);
                    end
                    if ($urandom_range(99) < 6)
                        repeat ($urandom_range(10, 6))
                            push_byte(8'($urandom_range(BYTE_DIGIT9, BYTE_DIGIT0)));
                    if ($urandom_range(99) < 10)
                    begin
                        // non-digit parameter char ends the number
                        push_byte(8'($urandom_range(8'h3F, 8'h3A)));
                        if ($urandom_range(1))
                            push_byte(8'($urandom_range(BYTE_DIGIT9, BYTE_DIGIT0)));
                    end
                    if ($urandom_range(99) < 10)
                    begin
                        // intermediate byte; later parameter chars are ignored
                        push_byte(8'($urandom_range(8'h2F, BYTE_INTER_LO)));
                        if ($urandom_range(1))
                            push_byte(8'($urandom_range(8'h3F, BYTE_DIGIT0)));
                    end
                    if ($urandom_range(99) < 10)
                        push_byte(csi_junk());
                    roll = $urandom_range(99);
                    if (roll < 65)
                        push_byte(BYTE_TILDE);
                    else if (roll < 85)
                        push_byte(8'($urandom_range(BYTE_KEY_D, BYTE_KEY_A)));
                    else
                        push_byte(8'($urandom_range(BYTE_TILDE, BYTE_PAR_END)));
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Byte sender: drives at the falling edge, sees acceptance at the rising edge
    // ------------------------------------------------------------------
    task automatic offer_byte(input key_row_t r);
        tekd_result_t exp_key;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= r.b;
        do
            @(posedge clk);
        while (!s_tready);
        // beat accepted: advance the model and queue the key event
        exp_key = predict_key(r.b);
        if (r.known)
            exp_key = '{evt: r.evt, char_code: r.cc, fkey_number: r.fk};
        key_expect_q.push_back(exp_key);
        @(negedge clk);
    endtask

    initial
    begin : key_sender
        int n_rand;
        int ph;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = 8'h00;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_req     = 1'b0;
        fail_cnt     = 0;
        esc_open     = 1'b0;
        drop_sequence();

        foreach (directed_rows[i])
            byte_plan.push_back(directed_rows[i]);
        build_key_traffic(RANDOM_BYTES);
        n_rand = byte_plan.size() - N_DIRECTED;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int i = 0; i < byte_plan.size(); i++)
        begin
            if (i >= N_DIRECTED)
            begin
                // four idling phases over the random traffic
                ph = ((i - N_DIRECTED) * 4) / n_rand;
                case (ph)
                    0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                    1:       begin tx_idle_pct = 58; rx_stall_pct = 0;  end
                    2:       begin tx_idle_pct = 0;  rx_stall_pct = 58; end
                    default: begin tx_idle_pct = 38; rx_stall_pct = 38; end
                endcase
            end
            // back-pressure burst while the sender streams without gaps
            if (i == N_DIRECTED)
                hold_req = 1'b1;
            offer_byte(byte_plan[i]);
        end
        s_tvalid <= 1'b0;

        while (key_expect_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_cnt == 0)
            $display("terminal_escape_key_decoder_tb OK");
        else
            $display("terminal_escape_key_decoder_tb NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------
    // Event receiver: random stalls, plus one long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin : key_receiver
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                for (int n = 0; n < HOLD_CYCLES; n++)
                begin
                    m_tready <= 1'b0;
                    @(negedge clk);
                end
                hold_req = 1'b0;
            end
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Event checker
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        tekd_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (key_expect_q.size() == 0)
            begin
                $error("key event beat with nothing expected: m_tdata=%h", m_tdata);
                fail_cnt++;
            end
            else
            begin
                want = key_expect_q.pop_front();
                if (m_tdata[4:0] !== want.evt)
                begin
                    $error("event_res: expected %0d, actual %0d", want.evt, m_tdata[4:0]);
                    fail_cnt++;
                end
                if (m_tdata[12:5] !== want.char_code)
                begin
                    $error("char_code: expected %h, actual %h", want.char_code, m_tdata[12:5]);
                    fail_cnt++;
                end
                if (m_tdata[16:13] !== want.fkey_number)
                begin
                    $error("fkey_number: expected %0d, actual %0d",
                           want.fkey_number, m_tdata[16:13]);
                    fail_cnt++;
                end
                if (m_tdata[23:17] !== 7'd0)
                begin
                    $error("tdata pad: expected 0, actual %h", m_tdata[23:17]);
                    fail_cnt++;
                end
            end
        end
    end

    // Watchdog
    initial
    begin : watchdog
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("terminal_escape_key_decoder_tb NOT OK");
        $finish;
    end

endmodule
